/* sv/u8d_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// Types and constants shared by the UTF-8 byte stream decoder modules.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam int BYTE_W   = 8;
	localparam int CP_W     = 21;
	localparam int STATUS_W = 3;
	localparam int BUF_N    = 4;
	localparam int CNT_W    = 3;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_END       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNEXP_END = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SURROGATE = 3'd4;

	localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_in;
		logic              end_mark;
	} u8d_in_t;

	typedef struct packed {
		logic [CP_W-1:0]     code_point;
		logic [STATUS_W-1:0] status;
		logic                last_of_run;
	} u8d_out_t;

	typedef logic [BUF_N-1:0][BYTE_W-1:0] u8d_buf_t;

	// one step of the decode unit
	typedef struct packed {
		logic                emit;
		logic [CNT_W-1:0]    used;
		logic [CP_W-1:0]     code_point;
		logic [STATUS_W-1:0] status;
	} u8d_step_t;

endpackage : u8d_pkg
`default_nettype wire

/* sv/u8d_parse.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_parse
// Decode unit: looks at the head of the byte buffer and tells whether one
// result can be made, its value and status, and how many bytes it uses.
// ----------------------------------------------------------------------------
module u8d_parse
	import u8d_pkg::*;
(
	input  wire u8d_buf_t         buf_bytes,
	input  wire logic [CNT_W-1:0] buf_cnt,
	output u8d_step_t             step
);

	logic [BYTE_W-1:0] b0, b1, b2, b3;
	logic [CP_W-1:0]   cp;

	assign b0 = buf_bytes[0];
	assign b1 = buf_bytes[1];
	assign b2 = buf_bytes[2];
	assign b3 = buf_bytes[3];

	always_comb begin
		step = '0;
		cp   = '0;
		if (buf_cnt == '0) begin
			step.emit = 1'b0;
		end else if (b0[7] == 1'b0) begin
			cp        = {13'b0, b0};
			step.emit = 1'b1;
			step.used = 3'd1;
		end else if (buf_cnt < 3'd2) begin
			step.emit = 1'b0;
		end else if (b0[7:5] == 3'b110) begin
			cp        = {10'b0, b0[4:0], b1[5:0]};
			step.emit = 1'b1;
			step.used = 3'd2;
		end else if (buf_cnt < 3'd3) begin
			step.emit = 1'b0;
		end else if (b0[7:4] == 4'b1110) begin
			cp        = {5'b0, b0[3:0], b1[5:0], b2[5:0]};
			step.emit = 1'b1;
			step.used = 3'd3;
		end else if (buf_cnt < 3'd4) begin
			step.emit = 1'b0;
		end else if (b0[7:3] == 5'b11110 && b0 <= 8'hF4) begin
			cp        = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			step.emit = 1'b1;
			step.used = 3'd4;
		end else begin
			// unknown lead with a full buffer: drop just the lead
			step.emit   = 1'b1;
			step.used   = 3'd1;
			step.status = ST_INVALID;
		end

		if (step.emit && step.status != ST_INVALID) begin
			if (cp >= SURR_LO && cp <= SURR_HI) begin
				step.status = ST_SURROGATE;
			end else begin
				step.status     = ST_OK;
				step.code_point = cp;
			end
		end
	end

endmodule : u8d_parse
`default_nettype wire

/* sv/u8d_out_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_out_reg
// Result output register; holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
module u8d_out_reg
	import u8d_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire u8d_out_t load_data,
	input  wire logic     stall,
	output logic          valid,
	output u8d_out_t      data,
	output logic          free
);

	logic     valid_q;
	u8d_out_t data_q;

	// slot is free when empty or being taken this cycle
	assign free  = !valid_q || !stall;
	assign valid = valid_q;
	assign data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= load_data;
		end
	end

endmodule : u8d_out_reg
`default_nettype wire

/* sv/utf8_byte_stream_decoder_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_core
// UTF-8 byte stream decoder: bytes or end markers in, code points with a
// status out. A small sequencer drives one shared decode unit over a
// four-byte buffer, one result per iteration.
// ----------------------------------------------------------------------------
//
//  channel   | valid      | stall      | payload
//  ----------+------------+------------+---------------------------------
//  byte in   | byte_valid | byte_stall | byte_req (byte_in, end_mark)
//  result    | cp_valid   | cp_stall   | cp_rsp (code_point, status, last)
//
//  A request is taken while idle, then the decode unit runs one step per
//  cycle while the result output is free; a request ends with a step that
//  emits nothing, also for an end marker or a byte that completes nothing.
//  The single decode unit gives one result per cycle while the output is free.
//  The last result of a request is held until the next step shows
//  that nothing follows it. Reset clears the count and all control state.
//  A stalled result output holds the sequencer; byte_stall stays high
//  while a request is being decoded.
//
module utf8_byte_stream_decoder_core
	import u8d_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    byte_valid,
	output logic         byte_stall,
	input  wire u8d_in_t byte_req,
	output logic         cp_valid,
	input  wire logic    cp_stall,
	output u8d_out_t     cp_rsp
);

	typedef enum logic {S_IDLE, S_PARSE} state_t;

	state_t           state_q;
	u8d_buf_t         buf_q;
	u8d_buf_t         buf_shift;
	logic [CNT_W-1:0] cnt_q;
	u8d_out_t         hold_q;
	logic             has_hold_q;
	u8d_step_t        step;
	logic             take;
	logic             out_load;
	u8d_out_t         out_data;
	logic             out_free;

	assign byte_stall = (state_q != S_IDLE);
	assign take       = byte_valid && !byte_stall;

	u8d_parse u_parse (
		.buf_bytes (buf_q),
		.buf_cnt   (cnt_q),
		.step      (step)
	);

	// held result goes out when the slot is free; last when nothing follows
	always_comb begin
		out_load             = (state_q == S_PARSE) && has_hold_q && out_free;
		out_data             = hold_q;
		out_data.last_of_run = !step.emit;
	end

	u8d_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.load_data (out_data),
		.stall     (cp_stall),
		.valid     (cp_valid),
		.data      (cp_rsp),
		.free      (out_free)
	);

	always_comb begin
		logic [CNT_W-1:0] sidx;
		for (int i = 0; i < BUF_N; i++) begin
			sidx         = CNT_W'(i) + step.used;
			buf_shift[i] = (sidx < CNT_W'(BUF_N)) ? buf_q[sidx[1:0]] : buf_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			has_hold_q <= 1'b0;
			hold_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_PARSE;
						if (byte_req.end_mark) begin
							hold_q.code_point  <= '0;
							hold_q.status      <= (cnt_q != '0) ? ST_UNEXP_END : ST_END;
							hold_q.last_of_run <= 1'b0;
							has_hold_q         <= 1'b1;
							cnt_q              <= '0;
						end else begin
							cnt_q <= cnt_q + 3'd1;
						end
					end
				end
				S_PARSE: begin
					if (step.emit) begin
						if (!has_hold_q || out_free) begin
							hold_q.code_point  <= step.code_point;
							hold_q.status      <= step.status;
							hold_q.last_of_run <= 1'b0;
							has_hold_q         <= 1'b1;
							cnt_q              <= cnt_q - step.used;
						end
					end else if (!has_hold_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						has_hold_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// byte buffer, no reset: only the first cnt_q entries are ever used
	always_ff @(posedge clk) begin
		if (take && !byte_req.end_mark) begin
			buf_q[cnt_q[1:0]] <= byte_req.byte_in;
		end else if (state_q == S_PARSE && step.emit && (!has_hold_q || out_free)) begin
			buf_q <= buf_shift;
		end
	end

	a_idle_no_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !has_hold_q)
		else $error("result held while idle");

	a_idle_cnt : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (cnt_q <= 3'd3))
		else $error("four bytes left pending");

	a_take_parse : assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == S_PARSE))
		else $error("request taken without decode pass");

	a_err_zero_cp : assert property (@(posedge clk) disable iff (!arst_n)
		(cp_valid && cp_rsp.status != ST_OK) |-> (cp_rsp.code_point == '0))
		else $error("error result carries a code point");

endmodule : utf8_byte_stream_decoder_core
`default_nettype wire
